/* hw/rtl/aozc_pkg.sv */
// ----------------------------------------------------------------------------
// aozc_pkg: shared types and helpers for the accelerometer zero/calibrate core
// Field widths, opcode, event and register codes, axis remap and sign tables.
// ----------------------------------------------------------------------------
package aozc_pkg;

    localparam int RAW_W      = 10;   // converter sample width
    localparam int ACC_W      = 12;   // signed axis result width
    localparam int DIFF_W     = 13;   // sample minus zero, before saturation
    localparam int VERT_W     = 14;   // signed vertical result width
    localparam int SY_W       = 12;   // signed smoothed yaw width
    localparam int ZERO_W     = 12;   // signed effective yaw zero width
    localparam int HALF_W     = 10;   // signed half span width
    localparam int ORIENT_W   = 3;
    localparam int OP_W       = 2;
    localparam int EV_W       = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    localparam int CAL_SAMPLES_DEF = 32;

    localparam logic [RAW_W-1:0] YAW_ZERO_RST = 10'd643;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIENT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_ZERO = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_READ     = 2'd0,
        OP_NORMAL   = 2'd1,
        OP_INVERTED = 2'd2
    } t_opcode;

    typedef enum logic [EV_W-1:0] {
        EV_NONE     = 3'd0,
        EV_NORMAL   = 3'd1,
        EV_ACCEPTED = 3'd2,
        EV_REJECTED = 3'd3,
        EV_IGNORED  = 3'd4
    } t_cal_event;

    typedef enum logic [1:0] {
        RUN_NONE     = 2'd0,
        RUN_NORMAL   = 2'd1,
        RUN_INVERTED = 2'd2
    } t_run_kind;

    localparam logic [ORIENT_W-1:0] ORIENT_NORMAL   = 3'd0;
    localparam logic [ORIENT_W-1:0] ORIENT_VERTICAL = 3'd1;
    localparam logic [ORIENT_W-1:0] ORIENT_UPSIDE   = 3'd2;
    localparam logic [ORIENT_W-1:0] ORIENT_AFT      = 3'd3;
    localparam logic [ORIENT_W-1:0] ORIENT_SIDEWAYS = 3'd4;
    localparam logic [ORIENT_W-1:0] ORIENT_PITCHUP  = 3'd5;

    typedef struct packed {
        logic [RAW_W-1:0] roll;
        logic [RAW_W-1:0] pitch;
        logic [RAW_W-1:0] yaw;
    } t_axes;

    // negate flags: set where the axis sign is minus one
    typedef struct packed {
        logic roll;
        logic pitch;
        logic yaw;
    } t_negate;

    typedef struct packed {
        logic [RAW_W-1:0]  roll;
        logic [RAW_W-1:0]  pitch;
        logic [ZERO_W-1:0] yaw;      // two's complement
        logic [RAW_W-1:0]  upright;
    } t_zeros;

    typedef struct packed {
        t_cal_event ev;
        logic       normal_done;
        logic       inverted_done;
    } t_cal_status;

    function automatic t_axes remap(input logic [ORIENT_W-1:0] orient,
                                    input logic [RAW_W-1:0] a,
                                    input logic [RAW_W-1:0] b,
                                    input logic [RAW_W-1:0] c);
        t_axes m;
        unique case (orient)
            ORIENT_VERTICAL: m = '{roll: c, pitch: a, yaw: b};
            ORIENT_SIDEWAYS: m = '{roll: b, pitch: a, yaw: c};
            ORIENT_PITCHUP:  m = '{roll: a, pitch: c, yaw: b};
            default:         m = '{roll: a, pitch: b, yaw: c};
        endcase
        return m;
    endfunction

    // unused orientation codes fall back to normal mounting
    function automatic t_negate axis_negate(input logic [ORIENT_W-1:0] orient);
        t_negate n;
        unique case (orient)
            ORIENT_VERTICAL: n = '{roll: 1'b1, pitch: 1'b0, yaw: 1'b1};
            ORIENT_UPSIDE:   n = '{roll: 1'b0, pitch: 1'b1, yaw: 1'b1};
            ORIENT_AFT:      n = '{roll: 1'b0, pitch: 1'b0, yaw: 1'b0};
            ORIENT_SIDEWAYS: n = '{roll: 1'b1, pitch: 1'b0, yaw: 1'b0};
            ORIENT_PITCHUP:  n = '{roll: 1'b1, pitch: 1'b1, yaw: 1'b1};
            default:         n = '{roll: 1'b1, pitch: 1'b1, yaw: 1'b0};
        endcase
        return n;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [DIFF_W-1:0] v);
        logic signed [DIFF_W-1:0] hi;
        logic signed [DIFF_W-1:0] lo;
        hi = DIFF_W'(2047);
        lo = -DIFF_W'(2048);
        if (v > hi) begin
            return ACC_W'(hi);
        end else if (v < lo) begin
            return ACC_W'(lo);
        end
        return v[ACC_W-1:0];
    endfunction

endpackage

/* hw/rtl/aozc_cal.sv */
// ----------------------------------------------------------------------------
// aozc_cal: calibration state and run accumulator
// Holds the axis zeros, half span and run sums; presents post-update values.
// ----------------------------------------------------------------------------
module aozc_cal #(
    parameter int CAL_SAMPLES = aozc_pkg::CAL_SAMPLES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [aozc_pkg::OP_W-1:0]     i_opcode,
    input  aozc_pkg::t_axes               i_mapped,
    input  logic                          i_yaw_negate,
    input  logic [aozc_pkg::RAW_W-1:0]    i_default_yaw_zero,
    output aozc_pkg::t_zeros              o_zeros,
    output aozc_pkg::t_cal_status         o_status
);

    localparam int RAW_W      = aozc_pkg::RAW_W;
    localparam int ZERO_W     = aozc_pkg::ZERO_W;
    localparam int HALF_W     = aozc_pkg::HALF_W;
    localparam int CAL_LOG    = $clog2(CAL_SAMPLES);
    localparam int CNT_W      = CAL_LOG;
    localparam int SUM_W      = RAW_W + CAL_LOG;
    // exact reciprocal: floor(x * RECIP >> MEAN_SHIFT) == floor(x / CAL_SAMPLES)
    localparam int MEAN_SHIFT = SUM_W + CAL_LOG;
    localparam int RECIP_W    = SUM_W + 1;
    localparam longint RECIP_INT =
        ((longint'(1) << MEAN_SHIFT) + longint'(CAL_SAMPLES) - 1) / longint'(CAL_SAMPLES);
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_INT);
    localparam logic [SUM_W-1:0]   ROUND    = SUM_W'(CAL_SAMPLES / 2);
    localparam logic [CNT_W-1:0]   LAST_CNT = CNT_W'(CAL_SAMPLES - 1);

    function automatic logic [RAW_W-1:0] mean_of(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0]         x;
        logic [SUM_W+RECIP_W-1:0] p;
        x = s + ROUND;
        p = (SUM_W + RECIP_W)'(x) * (SUM_W + RECIP_W)'(RECIP);
        return p[MEAN_SHIFT +: RAW_W];
    endfunction

    logic [RAW_W-1:0]         r_roll_zero,  n_roll_zero;
    logic [RAW_W-1:0]         r_pitch_zero, n_pitch_zero;
    logic [RAW_W-1:0]         r_upright,    n_upright;
    logic signed [HALF_W-1:0] r_half_span,  n_half_span;
    logic [SUM_W-1:0]         r_sum_roll,   n_sum_roll;
    logic [SUM_W-1:0]         r_sum_pitch,  n_sum_pitch;
    logic [SUM_W-1:0]         r_sum_yaw,    n_sum_yaw;
    logic [CNT_W-1:0]         r_count,      n_count;
    aozc_pkg::t_run_kind      r_run_kind,   n_run_kind;
    logic                     r_normal_done,   n_normal_done;
    logic                     r_inverted_done, n_inverted_done;

    aozc_pkg::t_run_kind      target_kind;
    logic                     same_run;
    logic [SUM_W-1:0]         base_roll, base_pitch, base_yaw;
    logic [SUM_W-1:0]         add_roll, add_pitch, add_yaw;
    logic [CNT_W-1:0]         base_count;
    logic                     run_last;
    logic [RAW_W-1:0]         mean_roll, mean_pitch, mean_yaw;
    logic signed [ZERO_W-1:0] cur_yaw_zero;
    logic signed [ZERO_W-1:0] inv_mean_s;
    logic signed [RAW_W:0]    span_diff;
    logic                     inv_ok;
    aozc_pkg::t_cal_event     ev;

    // a calibration item of another kind starts over from empty sums
    assign target_kind = (i_opcode == aozc_pkg::OP_INVERTED) ? aozc_pkg::RUN_INVERTED
                                                              : aozc_pkg::RUN_NORMAL;
    assign same_run   = (r_run_kind == target_kind);
    assign base_roll  = same_run ? r_sum_roll  : '0;
    assign base_pitch = same_run ? r_sum_pitch : '0;
    assign base_yaw   = same_run ? r_sum_yaw   : '0;
    assign base_count = same_run ? r_count     : '0;
    assign add_roll   = base_roll  + SUM_W'(i_mapped.roll);
    assign add_pitch  = base_pitch + SUM_W'(i_mapped.pitch);
    assign add_yaw    = base_yaw   + SUM_W'(i_mapped.yaw);
    assign run_last   = (base_count == LAST_CNT);

    assign mean_roll  = mean_of(add_roll);
    assign mean_pitch = mean_of(add_pitch);
    assign mean_yaw   = mean_of(add_yaw);

    assign cur_yaw_zero = r_inverted_done
        ? (ZERO_W'(r_upright) - ZERO_W'(r_half_span))
        : ZERO_W'(i_default_yaw_zero);
    assign inv_mean_s = $signed(ZERO_W'(mean_yaw));
    assign inv_ok     = i_yaw_negate ? (inv_mean_s > cur_yaw_zero)
                                     : (inv_mean_s < cur_yaw_zero);
    assign span_diff  = $signed({1'b0, r_upright}) - $signed({1'b0, mean_yaw});

    always_comb begin
        n_roll_zero     = r_roll_zero;
        n_pitch_zero    = r_pitch_zero;
        n_upright       = r_upright;
        n_half_span     = r_half_span;
        n_sum_roll      = r_sum_roll;
        n_sum_pitch     = r_sum_pitch;
        n_sum_yaw       = r_sum_yaw;
        n_count         = r_count;
        n_run_kind      = r_run_kind;
        n_normal_done   = r_normal_done;
        n_inverted_done = r_inverted_done;
        ev              = aozc_pkg::EV_NONE;
        unique case (i_opcode)
            aozc_pkg::OP_NORMAL: begin
                n_run_kind  = aozc_pkg::RUN_NORMAL;
                n_sum_roll  = add_roll;
                n_sum_pitch = add_pitch;
                n_sum_yaw   = add_yaw;
                n_count     = base_count + 1'b1;
                if (run_last) begin
                    n_roll_zero   = mean_roll;
                    n_pitch_zero  = mean_pitch;
                    n_upright     = mean_yaw;
                    n_normal_done = 1'b1;
                    ev            = aozc_pkg::EV_NORMAL;
                    n_run_kind    = aozc_pkg::RUN_NONE;
                    n_sum_roll    = '0;
                    n_sum_pitch   = '0;
                    n_sum_yaw     = '0;
                    n_count       = '0;
                end
            end
            aozc_pkg::OP_INVERTED: begin
                if (!r_normal_done) begin
                    ev          = aozc_pkg::EV_IGNORED;
                    n_run_kind  = aozc_pkg::RUN_NONE;
                    n_sum_roll  = '0;
                    n_sum_pitch = '0;
                    n_sum_yaw   = '0;
                    n_count     = '0;
                end else begin
                    n_run_kind  = aozc_pkg::RUN_INVERTED;
                    n_sum_roll  = base_roll;
                    n_sum_pitch = base_pitch;
                    n_sum_yaw   = add_yaw;
                    n_count     = base_count + 1'b1;
                    if (run_last) begin
                        if (inv_ok) begin
                            // floor of half the span
                            n_half_span     = span_diff[RAW_W:1];
                            n_inverted_done = 1'b1;
                            ev              = aozc_pkg::EV_ACCEPTED;
                        end else begin
                            ev = aozc_pkg::EV_REJECTED;
                        end
                        n_run_kind  = aozc_pkg::RUN_NONE;
                        n_sum_roll  = '0;
                        n_sum_pitch = '0;
                        n_sum_yaw   = '0;
                        n_count     = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll_zero     <= '0;
            r_pitch_zero    <= '0;
            r_upright       <= '0;
            r_half_span     <= '0;
            r_sum_roll      <= '0;
            r_sum_pitch     <= '0;
            r_sum_yaw       <= '0;
            r_count         <= '0;
            r_run_kind      <= aozc_pkg::RUN_NONE;
            r_normal_done   <= 1'b0;
            r_inverted_done <= 1'b0;
        end else if (i_fire) begin
            r_roll_zero     <= n_roll_zero;
            r_pitch_zero    <= n_pitch_zero;
            r_upright       <= n_upright;
            r_half_span     <= n_half_span;
            r_sum_roll      <= n_sum_roll;
            r_sum_pitch     <= n_sum_pitch;
            r_sum_yaw       <= n_sum_yaw;
            r_count         <= n_count;
            r_run_kind      <= n_run_kind;
            r_normal_done   <= n_normal_done;
            r_inverted_done <= n_inverted_done;
        end
    end

    // results see the zeros as left by this item
    assign o_zeros.roll    = n_roll_zero;
    assign o_zeros.pitch   = n_pitch_zero;
    assign o_zeros.upright = n_upright;
    assign o_zeros.yaw     = n_inverted_done
        ? (ZERO_W'(n_upright) - ZERO_W'(n_half_span))
        : ZERO_W'(i_default_yaw_zero);

    assign o_status.ev            = ev;
    assign o_status.normal_done   = n_normal_done;
    assign o_status.inverted_done = n_inverted_done;

    a_inv_needs_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inverted_done |-> r_normal_done)
        else $error("inverted calibration flagged without normal calibration");

    a_count_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_run_kind != aozc_pkg::RUN_NONE))
        else $error("sample count held with no active run");

    a_accept_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (o_status.ev == aozc_pkg::EV_ACCEPTED)) |=> r_inverted_done)
        else $error("accepted inverted run did not set its flag");

    a_inv_run_yaw_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run_kind == aozc_pkg::RUN_INVERTED) |-> (r_sum_roll == '0 && r_sum_pitch == '0))
        else $error("inverted run accumulated roll or pitch");

    a_read_keeps_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (i_opcode == aozc_pkg::OP_READ)) |=> ($stable(r_count) && $stable(r_run_kind)))
        else $error("read item disturbed the calibration run");

endmodule

/* hw/rtl/aozc_xform.sv */
// ----------------------------------------------------------------------------
// aozc_xform: zero removal, sign and vertical value
// Turns remapped axes and current zeros into the signed result fields.
// ----------------------------------------------------------------------------
module aozc_xform (
    input  aozc_pkg::t_axes                   i_mapped,
    input  aozc_pkg::t_negate                 i_negate,
    input  aozc_pkg::t_zeros                  i_zeros,
    input  logic signed [aozc_pkg::SY_W-1:0]  i_smooth_yaw,
    output logic signed [aozc_pkg::ACC_W-1:0] o_roll_acc,
    output logic signed [aozc_pkg::ACC_W-1:0] o_pitch_acc,
    output logic signed [aozc_pkg::ACC_W-1:0] o_yaw_acc,
    output logic signed [aozc_pkg::VERT_W-1:0] o_vert_acc
);

    localparam int DIFF_W = aozc_pkg::DIFF_W;
    localparam int VERT_W = aozc_pkg::VERT_W;

    logic signed [DIFF_W-1:0] roll_diff, pitch_diff, yaw_diff;
    logic signed [DIFF_W-1:0] roll_sgn, pitch_sgn, yaw_sgn;

    assign roll_diff  = $signed(DIFF_W'(i_mapped.roll))  - $signed(DIFF_W'(i_zeros.roll));
    assign pitch_diff = $signed(DIFF_W'(i_mapped.pitch)) - $signed(DIFF_W'(i_zeros.pitch));
    assign yaw_diff   = $signed(DIFF_W'(i_mapped.yaw))
                      - $signed({i_zeros.yaw[aozc_pkg::ZERO_W-1], i_zeros.yaw});

    assign roll_sgn  = i_negate.roll  ? -roll_diff  : roll_diff;
    assign pitch_sgn = i_negate.pitch ? -pitch_diff : pitch_diff;
    assign yaw_sgn   = i_negate.yaw   ? -yaw_diff   : yaw_diff;

    assign o_roll_acc  = aozc_pkg::sat_acc(roll_sgn);
    assign o_pitch_acc = aozc_pkg::sat_acc(pitch_sgn);
    assign o_yaw_acc   = aozc_pkg::sat_acc(yaw_sgn);

    assign o_vert_acc = VERT_W'(i_smooth_yaw)
                      - VERT_W'($signed(i_zeros.yaw))
                      + $signed(VERT_W'(i_zeros.upright));

endmodule

/* hw/rtl/accel_orient_zero_calibrate_core.sv */
// ----------------------------------------------------------------------------
// accel_orient_zero_calibrate_core: accelerometer remap, zeroing, calibration
// Top level: input register, calibration state, result register, config regs.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (i_in_valid / o_in_stall): one item per accepted edge, made
//   of an opcode, three raw converter samples and a smoothed vertical value.
//   Opcode read gives results only; normal and inverted opcodes also feed
//   the calibration run of CAL_SAMPLES items, whose last item reports the
//   event on the same result; inverted before normal reports ignored.
//   Output channel (o_out_valid / i_out_stall): one result per item, in order.
//   Config channel (i_cfg_valid / o_cfg_ready): always ready; index 0 writes
//   the mounting orientation, index 1 the default yaw zero. Write only while
//   no item is in flight.
// Timing
//   An accepted item goes into the input register, then through remap,
//   calibration update and zeroing into the result register. Throughput
//   is one item per cycle while the output is not stalled; the calibration
//   state updates in the same cycle as the result register loads.
// Reset and stall
//   Reset empties both registers, clears all zeros and run state, and sets
//   orientation to normal and the default yaw zero to 643. While the receiver
//   stalls a held result, the input register still fills once, then stall
//   reaches the input side; nothing is dropped.
// ----------------------------------------------------------------------------
module accel_orient_zero_calibrate_core #(
    parameter int CAL_SAMPLES = aozc_pkg::CAL_SAMPLES_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // input channel
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic [aozc_pkg::OP_W-1:0]               i_opcode,
    input  logic [aozc_pkg::RAW_W-1:0]              i_raw_chan_a,
    input  logic [aozc_pkg::RAW_W-1:0]              i_raw_chan_b,
    input  logic [aozc_pkg::RAW_W-1:0]              i_raw_chan_c,
    input  logic signed [aozc_pkg::SY_W-1:0]        i_smooth_yaw,
    // output channel
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [aozc_pkg::ACC_W-1:0]       o_roll_acc,
    output logic signed [aozc_pkg::ACC_W-1:0]       o_pitch_acc,
    output logic signed [aozc_pkg::ACC_W-1:0]       o_yaw_acc,
    output logic signed [aozc_pkg::VERT_W-1:0]      o_vert_acc,
    output logic [aozc_pkg::EV_W-1:0]               o_cal_event,
    output logic                                    o_normal_cal_valid,
    output logic                                    o_inverted_cal_valid,
    // configuration channel
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [aozc_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [aozc_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    localparam int RAW_W    = aozc_pkg::RAW_W;
    localparam int ORIENT_W = aozc_pkg::ORIENT_W;

    // configuration registers
    logic [ORIENT_W-1:0]                  r_orientation;
    logic [RAW_W-1:0]                     r_default_yaw_zero;

    // input register
    logic                                 r_in_valid;
    logic [aozc_pkg::OP_W-1:0]            r_opcode;
    logic [RAW_W-1:0]                     r_raw_a, r_raw_b, r_raw_c;
    logic signed [aozc_pkg::SY_W-1:0]     r_smooth_yaw;

    // result register
    logic                                 r_out_valid;
    logic signed [aozc_pkg::ACC_W-1:0]    r_roll_acc, r_pitch_acc, r_yaw_acc;
    logic signed [aozc_pkg::VERT_W-1:0]   r_vert_acc;
    logic [aozc_pkg::EV_W-1:0]            r_cal_event;
    logic                                 r_normal_done, r_inverted_done;

    logic                                 advance;
    logic                                 fire;
    aozc_pkg::t_axes                      mapped;
    aozc_pkg::t_negate                    negate;
    aozc_pkg::t_zeros                     zeros;
    aozc_pkg::t_cal_status                status;
    logic signed [aozc_pkg::ACC_W-1:0]    roll_acc, pitch_acc, yaw_acc;
    logic signed [aozc_pkg::VERT_W-1:0]   vert_acc;

    // result register moves when empty or drained this cycle
    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign o_cfg_ready = 1'b1;

    // config writes: the user must write only while idle, so no ordering against items; the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orientation      <= aozc_pkg::ORIENT_NORMAL;
            r_default_yaw_zero <= aozc_pkg::YAW_ZERO_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                aozc_pkg::CFG_ORIENT:   r_orientation      <= i_cfg_data[ORIENT_W-1:0];
                aozc_pkg::CFG_YAW_ZERO: r_default_yaw_zero <= i_cfg_data[RAW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register: hold while stalled, load otherwise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_opcode     <= i_opcode;
            r_raw_a      <= i_raw_chan_a;
            r_raw_b      <= i_raw_chan_b;
            r_raw_c      <= i_raw_chan_c;
            r_smooth_yaw <= i_smooth_yaw;
        end
    end

    // remap sensor axes into roll, pitch, yaw order for this mounting
    assign mapped = aozc_pkg::remap(r_orientation, r_raw_a, r_raw_b, r_raw_c);
    assign negate = aozc_pkg::axis_negate(r_orientation);

    aozc_cal #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_cal (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_fire             (fire),
        .i_opcode           (r_opcode),
        .i_mapped           (mapped),
        .i_yaw_negate       (negate.yaw),
        .i_default_yaw_zero (r_default_yaw_zero),
        .o_zeros            (zeros),
        .o_status           (status)
    );

    aozc_xform u_xform (
        .i_mapped     (mapped),
        .i_negate     (negate),
        .i_zeros      (zeros),
        .i_smooth_yaw (r_smooth_yaw),
        .o_roll_acc   (roll_acc),
        .o_pitch_acc  (pitch_acc),
        .o_yaw_acc    (yaw_acc),
        .o_vert_acc   (vert_acc)
    );

    // result register: advance when empty or when the receiver takes the held item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_roll_acc      <= roll_acc;
            r_pitch_acc     <= pitch_acc;
            r_yaw_acc       <= yaw_acc;
            r_vert_acc      <= vert_acc;
            r_cal_event     <= status.ev;
            r_normal_done   <= status.normal_done;
            r_inverted_done <= status.inverted_done;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_roll_acc           = r_roll_acc;
    assign o_pitch_acc          = r_pitch_acc;
    assign o_yaw_acc            = r_yaw_acc;
    assign o_vert_acc           = r_vert_acc;
    assign o_cal_event          = r_cal_event;
    assign o_normal_cal_valid   = r_normal_done;
    assign o_inverted_cal_valid = r_inverted_done;

endmodule
